@@ rtl/core/boot_image_header_crc_verifier_assert.svh @@
// assertion helpers for the verifier back end
// both expect aclk and aresetn in scope
`ifndef BOOT_IMAGE_HEADER_CRC_VERIFIER_ASSERT_SVH
`define BOOT_IMAGE_HEADER_CRC_VERIFIER_ASSERT_SVH

// same-cycle implication
`define BIHCV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BIHCV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bihcv_pkg.sv @@
`timescale 1ns / 1ps
package bihcv_pkg;

    // status codes, also used as header field tags
    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_LENGTH  = 4'd1;
    localparam logic [3:0] ST_MAGIC   = 4'd2;
    localparam logic [3:0] ST_VERSION = 4'd3;
    localparam logic [3:0] ST_HSIZE   = 4'd4;
    localparam logic [3:0] ST_PROFILE = 4'd5;
    localparam logic [3:0] ST_LOAD    = 4'd6;
    localparam logic [3:0] ST_ENTRY   = 4'd7;
    localparam logic [3:0] ST_CRC     = 4'd8;
    localparam logic [3:0] FLD_CRC    = 4'd15;

    // word kinds
    localparam logic [1:0] KIND_FIELD   = 2'd0;
    localparam logic [1:0] KIND_PAD     = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // register indexes
    localparam logic [2:0] REG_IMAGE_MAGIC    = 3'd0;
    localparam logic [2:0] REG_FORMAT_VERSION = 3'd1;
    localparam logic [2:0] REG_BUILD_PROFILE  = 3'd2;
    localparam logic [2:0] REG_LOAD_ADDRESS   = 3'd3;
    localparam logic [2:0] REG_ENTRY_ADDRESS  = 3'd4;
    localparam logic [2:0] REG_PAYLOAD_LENGTH = 3'd5;
    localparam logic [2:0] REG_CRC_INIT       = 3'd6;
    localparam logic [2:0] REG_CRC_POLY       = 3'd7;

    localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
    localparam logic [15:0] CRC_TOP_BIT    = 16'h8000;
    localparam int          CRC_BITS       = 8;

    localparam int HDR_IDX_W = 5;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    typedef struct packed {
        logic [31:0] image_magic;
        logic [7:0]  format_version;
        logic [31:0] build_profile_id;
        logic [15:0] load_address;
        logic [15:0] entry_address;
        logic [15:0] payload_length;
        logic [15:0] crc_init;
        logic [15:0] crc_poly;
    } cfg_t;

    typedef struct packed {
        logic       in_field;
        logic [3:0] field;
        logic [1:0] off;
        logic       last;
    } hdr_class_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic [1:0] kind;
        logic [3:0] field;
        logic [1:0] off;
        logic       last;
    } entry_t;

    function automatic hdr_class_t classify_hdr(logic [HDR_IDX_W-1:0] idx);
        hdr_class_t         c;
        logic [HDR_IDX_W-1:0] first;
        logic [HDR_IDX_W-1:0] len;
        logic [HDR_IDX_W-1:0] rel;
        c.in_field = 1'b1;
        c.field    = ST_MAGIC;
        first      = 5'd0;
        len        = 5'd4;
        priority if (idx < 5'd4) begin
            c.field = ST_MAGIC;   first = 5'd0;  len = 5'd4;
        end else if (idx == 5'd4) begin
            c.field = ST_VERSION; first = 5'd4;  len = 5'd1;
        end else if (idx == 5'd5) begin
            c.field = ST_HSIZE;   first = 5'd5;  len = 5'd1;
        end else if (idx < 5'd10) begin
            c.field = ST_PROFILE; first = 5'd6;  len = 5'd4;
        end else if (idx < 5'd12) begin
            c.field = ST_LOAD;    first = 5'd10; len = 5'd2;
        end else if (idx < 5'd14) begin
            c.field = ST_ENTRY;   first = 5'd12; len = 5'd2;
        end else if (idx < 5'd16) begin
            c.field = ST_LENGTH;  first = 5'd14; len = 5'd2;
        end else if (idx < 5'd18) begin
            c.field = FLD_CRC;    first = 5'd16; len = 5'd2;
        end else begin
            c.in_field = 1'b0;    first = idx;   len = 5'd1;
        end
        rel    = idx - first;
        c.off  = rel[1:0];
        c.last = (rel == len - 5'd1);
        return c;
    endfunction

    // one byte through an msb-first crc-16
    function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b,
                                              logic [15:0] poly);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < CRC_BITS; k++) begin
            if ((r & CRC_TOP_BIT) != 16'h0000) begin
                r = {r[14:0], 1'b0} ^ poly;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/boot_image_header_crc_verifier.sv @@
`timescale 1ns / 1ps
// boot image header check with payload crc-16
//
// s_ channel: one image byte per word in s_tdata, s_tuser high on the first
// header byte of an image. the header is compared field by field against the
// cfg registers; the payload is run through an msb-first crc-16 and compared
// with header bytes 16 and 17.
// m_ channel: at most one word per image, status and the crc so far, given at
// the first mismatch or after the last payload byte. later bytes are dropped
// until the next image start.
// cfg channel: register index and data, always ready, write only while idle.
// throughput: one byte per cycle while the queue has room, limited by the
// single crc byte step in the back end. a byte is held in the queue until the
// output register is free or being drained; its result is registered there.
// a two-word queue sits between the byte classifier and the checker, so input
// keeps flowing while a result waits; when m_tready stays low the queue fills
// and s_tready drops after two more bytes.
// reset: registers take their defaults (crc init 0xffff, poly 0x1021, rest
// zero), the queue empties and the checker waits for an image start.
module boot_image_header_crc_verifier #(
    parameter int HEADER_BYTES = 18
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic [0:0]  s_tuser,    // image_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // status[3:0], crc_value[19:4], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    bihcv_pkg::cfg_t   cfg_reg;
    bihcv_pkg::entry_t push_entry;
    bihcv_pkg::entry_t head;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{image_magic: 32'h0, format_version: 8'h0,
                         build_profile_id: 32'h0, load_address: 16'h0,
                         entry_address: 16'h0, payload_length: 16'h0,
                         crc_init: bihcv_pkg::CRC_INIT_RESET,
                         crc_poly: bihcv_pkg::CRC_POLY_RESET};
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                bihcv_pkg::REG_IMAGE_MAGIC:    cfg_reg.image_magic      <= cfg_wdata;
                bihcv_pkg::REG_FORMAT_VERSION: cfg_reg.format_version   <= cfg_wdata[7:0];
                bihcv_pkg::REG_BUILD_PROFILE:  cfg_reg.build_profile_id <= cfg_wdata;
                bihcv_pkg::REG_LOAD_ADDRESS:   cfg_reg.load_address     <= cfg_wdata[15:0];
                bihcv_pkg::REG_ENTRY_ADDRESS:  cfg_reg.entry_address    <= cfg_wdata[15:0];
                bihcv_pkg::REG_PAYLOAD_LENGTH: cfg_reg.payload_length   <= cfg_wdata[15:0];
                bihcv_pkg::REG_CRC_INIT:       cfg_reg.crc_init         <= cfg_wdata[15:0];
                bihcv_pkg::REG_CRC_POLY:       cfg_reg.crc_poly         <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    bihcv_front #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (full),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    bihcv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    bihcv_back #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (empty),
        .q_head   (head),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ rtl/core/bihcv_front.sv @@
`timescale 1ns / 1ps
module bihcv_front #(
    parameter int HEADER_BYTES = 18
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // data_byte
    input  logic [0:0]           s_tuser,   // image_start
    input  logic                 q_full,
    output logic                 q_push,
    output bihcv_pkg::entry_t    q_entry
);

    localparam int CntW = $clog2(HEADER_BYTES + 1);
    localparam int IdxW = bihcv_pkg::HDR_IDX_W;
    localparam logic [CntW-1:0] HdrEnd = CntW'(HEADER_BYTES);

    logic [CntW-1:0]       hdr_cnt_reg;
    logic [CntW-1:0]       hdr_cnt_next;
    logic [CntW-1:0]       cur_idx;
    bihcv_pkg::hdr_class_t cls;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // position within the header, held at the header length once in the payload
    always_comb begin
        cur_idx = s_tuser[0] ? '0 : hdr_cnt_reg;
        cls     = bihcv_pkg::classify_hdr(IdxW'(cur_idx));
        hdr_cnt_next = hdr_cnt_reg;
        if (q_push) begin
            hdr_cnt_next = (cur_idx == HdrEnd) ? HdrEnd : cur_idx + 1'b1;
        end
        q_entry.data  = s_tdata;
        q_entry.start = s_tuser[0];
        q_entry.field = cls.field;
        q_entry.off   = cls.off;
        q_entry.last  = cls.last;
        if (cur_idx == HdrEnd) begin
            q_entry.kind = bihcv_pkg::KIND_PAYLOAD;
        end else if (cls.in_field) begin
            q_entry.kind = bihcv_pkg::KIND_FIELD;
        end else begin
            q_entry.kind = bihcv_pkg::KIND_PAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_cnt_reg <= HdrEnd;
        end else begin
            hdr_cnt_reg <= hdr_cnt_next;
        end
    end

endmodule

@@ rtl/core/bihcv_queue.sv @@
`timescale 1ns / 1ps
module bihcv_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bihcv_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output bihcv_pkg::entry_t head,
    output logic              empty
);

    bihcv_pkg::entry_t              slot_reg [bihcv_pkg::Q_DEPTH];
    logic [bihcv_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [bihcv_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [bihcv_pkg::Q_CNT_W-1:0]  count_reg;
    logic [bihcv_pkg::Q_CNT_W-1:0]  count_next;

    assign full  = (count_reg == bihcv_pkg::Q_CNT_W'(bihcv_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/bihcv_back.sv @@
`timescale 1ns / 1ps
`include "boot_image_header_crc_verifier_assert.svh"
module bihcv_back #(
    parameter int HEADER_BYTES = 18
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bihcv_pkg::cfg_t   cfg,
    input  logic              q_empty,
    input  bihcv_pkg::entry_t q_head,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata    // status[3:0], crc_value[19:4], zero pad
);

    localparam logic [16:0] HdrLen   = 17'(HEADER_BYTES);
    localparam logic [31:0] HsizeExp = 32'(HEADER_BYTES % 256);

    logic        m_valid_reg, m_valid_next;
    logic [3:0]  status_reg, status_next;
    logic [15:0] crcv_reg, crcv_next;
    logic        verdict_reg, verdict_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] pay_cnt_reg, pay_cnt_next;
    logic [31:0] accum_reg, accum_next;
    logic [15:0] stored_reg, stored_next;

    logic        emit;
    logic [3:0]  emit_code;
    logic [15:0] emit_crc;
    logic [15:0] crc_base;
    logic        verdict_cur;
    logic [15:0] cnt_cur;
    logic [31:0] acc;
    logic [15:0] crc_new;

    function automatic logic [31:0] expected_for(logic [3:0] code, bihcv_pkg::cfg_t c);
        logic [31:0] v;
        unique case (code)
            bihcv_pkg::ST_MAGIC:   v = c.image_magic;
            bihcv_pkg::ST_VERSION: v = {24'h0, c.format_version};
            bihcv_pkg::ST_HSIZE:   v = HsizeExp;
            bihcv_pkg::ST_PROFILE: v = c.build_profile_id;
            bihcv_pkg::ST_LOAD:    v = {16'h0, c.load_address};
            bihcv_pkg::ST_ENTRY:   v = {16'h0, c.entry_address};
            default:               v = {16'h0, c.payload_length};
        endcase
        return v;
    endfunction

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'h0, crcv_reg, status_reg};

    // take a word only when the output register is free or being drained
    assign q_pop = !q_empty && (!m_valid_reg || m_tready);

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        crcv_next    = crcv_reg;
        verdict_next = verdict_reg;
        crc_next     = crc_reg;
        pay_cnt_next = pay_cnt_reg;
        accum_next   = accum_reg;
        stored_next  = stored_reg;
        emit         = 1'b0;
        emit_code    = bihcv_pkg::ST_OK;
        crc_base     = crc_reg;
        verdict_cur  = verdict_reg;
        cnt_cur      = pay_cnt_reg;
        emit_crc     = crc_reg;
        acc          = '0;
        crc_new      = bihcv_pkg::crc16_byte(crc_reg, q_head.data, cfg.crc_poly);
        if (q_pop) begin
            if (q_head.start) begin
                crc_base     = cfg.crc_init;
                verdict_cur  = 1'b0;
                cnt_cur      = '0;
                crc_next     = cfg.crc_init;
                verdict_next = 1'b0;
                pay_cnt_next = '0;
            end
            emit_crc = crc_base;
            if (q_head.start && (cfg.load_address == 16'h0000 ||
                                 {1'b0, cfg.payload_length} < HdrLen)) begin
                emit      = 1'b1;
                emit_code = bihcv_pkg::ST_LENGTH;
            end else if (!verdict_cur) begin
                unique case (q_head.kind)
                    bihcv_pkg::KIND_FIELD: begin
                        if (q_head.off == 2'd0) begin
                            acc = {24'h0, q_head.data};
                        end else begin
                            acc = accum_reg | (32'(q_head.data) << {q_head.off, 3'b000});
                        end
                        accum_next = acc;
                        if (q_head.last) begin
                            if (q_head.field == bihcv_pkg::FLD_CRC) begin
                                stored_next = acc[15:0];
                            end else if (acc != expected_for(q_head.field, cfg)) begin
                                emit      = 1'b1;
                                emit_code = q_head.field;
                            end
                        end
                    end
                    bihcv_pkg::KIND_PAYLOAD: begin
                        crc_next     = crc_new;
                        pay_cnt_next = cnt_cur + 16'd1;
                        if ({1'b0, cnt_cur} + 17'd1 >= {1'b0, cfg.payload_length}) begin
                            emit      = 1'b1;
                            emit_crc  = crc_new;
                            emit_code = (crc_new == stored_reg) ? bihcv_pkg::ST_OK
                                                                : bihcv_pkg::ST_CRC;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (emit) begin
                verdict_next = 1'b1;
                m_valid_next = 1'b1;
                status_next  = emit_code;
                crcv_next    = emit_crc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        crcv_reg   <= crcv_next;
        accum_reg  <= accum_next;
        stored_reg <= stored_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            verdict_reg <= 1'b1;
            crc_reg     <= bihcv_pkg::CRC_INIT_RESET;
            pay_cnt_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            verdict_reg <= verdict_next;
            crc_reg     <= crc_next;
            pay_cnt_reg <= pay_cnt_next;
        end
    end

    `BIHCV_ASSERT_NEXT(a_result_needs_word, !q_pop && !m_valid_reg, !m_valid_reg, "result without a word")
    `BIHCV_ASSERT_NEXT(a_silent_after_verdict, q_pop && verdict_reg && !q_head.start, !m_valid_reg, "result after verdict")
    `BIHCV_ASSERT_NEXT(a_early_length, q_pop && q_head.start && cfg.load_address == 16'h0000, m_valid_reg && status_reg == bihcv_pkg::ST_LENGTH, "missed early length failure")
    `BIHCV_ASSERT_NOW(a_status_range, m_valid_reg, status_reg <= bihcv_pkg::ST_CRC, "status code out of range")

endmodule

@@ tb/sv/tb_boot_image_header_crc_verifier.sv @@
`timescale 1ns / 1ps
module tb_boot_image_header_crc_verifier;

    localparam int HDR_LEN     = 18;
    localparam int NUM_REGS    = int'(bihcv_pkg::REG_CRC_POLY) + 1;
    localparam int SETTLE      = 8;
    localparam int STALL_LIMIT = 3000;
    localparam int IDLE_PCT    = 29;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_GOAL   = 700;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] crc;
    } verdict_t;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef enum {SET_RANDOM, SET_ONES, SET_ZEROS, SET_BAD_LENGTH} setting_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  addr;
        logic [31:0] value;
        logic        start;
        bit          fixed;
        logic [3:0]  status;
        logic [15:0] crc;
    } dir_row_t;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } img_byte_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // data_byte
    logic [0:0]  s_tuser;    // image_start
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // status[3:0], crc_value[19:4], zero pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    // expectation override travelling with the word on the input side
    bit          row_fixed  = 1'b0;
    logic [3:0]  row_status = bihcv_pkg::ST_OK;
    logic [15:0] row_crc    = 16'h0000;

    // predictor copy of the registers
    logic [31:0] c_magic   = 32'h0;
    logic [7:0]  c_version = 8'h0;
    logic [31:0] c_profile = 32'h0;
    logic [15:0] c_load    = 16'h0;
    logic [15:0] c_entry   = 16'h0;
    logic [15:0] c_length  = 16'h0;
    logic [15:0] c_init    = bihcv_pkg::CRC_INIT_RESET;
    logic [15:0] c_poly    = bihcv_pkg::CRC_POLY_RESET;

    // predictor copy of the image state
    logic [16:0] pos      = 17'h0;
    logic [15:0] crc_run  = bihcv_pkg::CRC_INIT_RESET;
    logic [31:0] accum    = 32'h0;
    logic [15:0] hdr_crc  = 16'h0;
    bit          img_done = 1'b1;

    verdict_t    verdict_q [$];
    img_byte_t   img_q [$];
    logic [31:0] next_regs [NUM_REGS];
    bit          no_gaps        = 1'b0;
    int          hold_len       = 0;
    int          accepted_items = 0;
    int          fault_count    = 0;

    boot_image_header_crc_verifier #(
        .HEADER_BYTES(HDR_LEN)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [15:0] advance_crc(logic [15:0] crc, logic [7:0] b,
                                                logic [15:0] poly);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        repeat (8) begin
            r = r[15] ? ((r << 1) ^ poly) : (r << 1);
        end
        return r;
    endfunction

    // walks one accepted byte through the header checks and the payload crc
    function automatic bit judge_byte(input logic [7:0] b, input logic st,
                                      output verdict_t v);
        int          idx;
        int          first;
        int          len;
        int          off;
        logic [3:0]  code;
        logic [31:0] want;
        v = '0;
        if (st) begin
            pos      = 17'h0;
            crc_run  = c_init;
            accum    = 32'h0;
            hdr_crc  = 16'h0;
            img_done = 1'b0;
            if (c_load == 16'h0000 || c_length < HDR_LEN) begin
                img_done = 1'b1;
                v.status = bihcv_pkg::ST_LENGTH;
                v.crc    = crc_run;
                return 1'b1;
            end
        end else if (img_done) begin
            return 1'b0;
        end
        idx = int'(pos);
        pos = pos + 17'h1;
        if (idx < HDR_LEN) begin
            if (idx < 4) begin
                first = 0;  len = 4; code = bihcv_pkg::ST_MAGIC;   want = c_magic;
            end else if (idx == 4) begin
                first = 4;  len = 1; code = bihcv_pkg::ST_VERSION; want = {24'h0, c_version};
            end else if (idx == 5) begin
                first = 5;  len = 1; code = bihcv_pkg::ST_HSIZE;   want = 32'(HDR_LEN);
            end else if (idx < 10) begin
                first = 6;  len = 4; code = bihcv_pkg::ST_PROFILE; want = c_profile;
            end else if (idx < 12) begin
                first = 10; len = 2; code = bihcv_pkg::ST_LOAD;    want = {16'h0, c_load};
            end else if (idx < 14) begin
                first = 12; len = 2; code = bihcv_pkg::ST_ENTRY;   want = {16'h0, c_entry};
            end else if (idx < 16) begin
                first = 14; len = 2; code = bihcv_pkg::ST_LENGTH;  want = {16'h0, c_length};
            end else begin
                first = 16; len = 2; code = bihcv_pkg::FLD_CRC;    want = 32'h0;
            end
            off = idx - first;
            if (off == 0) begin
                accum = 32'(b);
            end else begin
                accum = accum | (32'(b) << (8 * off));
            end
            if (off == len - 1) begin
                if (code == bihcv_pkg::FLD_CRC) begin
                    hdr_crc = accum[15:0];
                end else if (accum != want) begin
                    img_done = 1'b1;
                    v.status = code;
                    v.crc    = crc_run;
                    return 1'b1;
                end
            end
            return 1'b0;
        end
        crc_run = advance_crc(crc_run, b, c_poly);
        if (idx - HDR_LEN + 1 >= int'(c_length)) begin
            img_done = 1'b1;
            v.status = (crc_run == hdr_crc) ? bihcv_pkg::ST_OK : bihcv_pkg::ST_CRC;
            v.crc    = crc_run;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        verdict_t v;
        verdict_t want;
        bit       got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    bihcv_pkg::REG_IMAGE_MAGIC:    c_magic   = cfg_wdata;
                    bihcv_pkg::REG_FORMAT_VERSION: c_version = cfg_wdata[7:0];
                    bihcv_pkg::REG_BUILD_PROFILE:  c_profile = cfg_wdata;
                    bihcv_pkg::REG_LOAD_ADDRESS:   c_load    = cfg_wdata[15:0];
                    bihcv_pkg::REG_ENTRY_ADDRESS:  c_entry   = cfg_wdata[15:0];
                    bihcv_pkg::REG_PAYLOAD_LENGTH: c_length  = cfg_wdata[15:0];
                    bihcv_pkg::REG_CRC_INIT:       c_init    = cfg_wdata[15:0];
                    bihcv_pkg::REG_CRC_POLY:       c_poly    = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                accepted_items++;
                got = judge_byte(s_tdata, s_tuser[0], v);
                if (row_fixed) begin
                    v.status = row_status;
                    v.crc    = row_crc;
                end
                if (got || row_fixed) begin
                    verdict_q.push_back(v);
                end
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    note_fault($sformatf("unexpected word: status %0d crc %04h",
                                         m_tdata[3:0], m_tdata[19:4]));
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[3:0] !== want.status || m_tdata[19:4] !== want.crc) begin
                        note_fault($sformatf(
                            "mismatch: expected status %0d crc %04h, got status %0d crc %04h",
                            want.status, want.crc, m_tdata[3:0], m_tdata[19:4]));
                    end
                end
            end
        end
    end

    // receiver: random back-pressure, or a long hold-off on request
    initial begin : sink
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(negedge aclk);
                hold_len = 0;
            end
            m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_word(input logic [7:0] d, input logic st, input bit fx,
                             input logic [3:0] fs, input logic [15:0] fc);
        @(negedge aclk);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= d;
        s_tuser    <= st;
        row_fixed  <= fx;
        row_status <= fs;
        row_crc    <= fc;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending, let every expected word arrive and the pipeline empty
    task automatic settle_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_regs();
        settle_block();
        for (int r = 0; r < NUM_REGS; r++) begin
            write_reg(3'(r), next_regs[r]);
        end
    endtask

    task automatic pick_settings(input setting_t mode);
        next_regs[bihcv_pkg::REG_IMAGE_MAGIC]    = $urandom();
        next_regs[bihcv_pkg::REG_FORMAT_VERSION] = $urandom_range(0, 255);
        next_regs[bihcv_pkg::REG_BUILD_PROFILE]  = $urandom();
        next_regs[bihcv_pkg::REG_LOAD_ADDRESS]   = $urandom_range(1, 65535);
        next_regs[bihcv_pkg::REG_ENTRY_ADDRESS]  = $urandom_range(0, 65535);
        next_regs[bihcv_pkg::REG_PAYLOAD_LENGTH] = $urandom_range(HDR_LEN, 40);
        next_regs[bihcv_pkg::REG_CRC_INIT]       = $urandom_range(0, 65535);
        next_regs[bihcv_pkg::REG_CRC_POLY]       = $urandom_range(0, 65535);
        case (mode)
            SET_ONES: begin
                next_regs[bihcv_pkg::REG_IMAGE_MAGIC]    = 32'hFFFF_FFFF;
                next_regs[bihcv_pkg::REG_FORMAT_VERSION] = 32'h0000_00FF;
                next_regs[bihcv_pkg::REG_BUILD_PROFILE]  = 32'hFFFF_FFFF;
                next_regs[bihcv_pkg::REG_LOAD_ADDRESS]   = 32'h0000_FFFF;
                next_regs[bihcv_pkg::REG_ENTRY_ADDRESS]  = 32'h0000_FFFF;
                next_regs[bihcv_pkg::REG_PAYLOAD_LENGTH] = 32'(HDR_LEN);
                next_regs[bihcv_pkg::REG_CRC_INIT]       = 32'h0000_FFFF;
                next_regs[bihcv_pkg::REG_CRC_POLY]       = 32'h0000_FFFF;
            end
            SET_ZEROS: begin
                next_regs[bihcv_pkg::REG_IMAGE_MAGIC]    = 32'h0;
                next_regs[bihcv_pkg::REG_FORMAT_VERSION] = 32'h0;
                next_regs[bihcv_pkg::REG_BUILD_PROFILE]  = 32'h0;
                next_regs[bihcv_pkg::REG_LOAD_ADDRESS]   = 32'h1;
                next_regs[bihcv_pkg::REG_ENTRY_ADDRESS]  = 32'h0;
                next_regs[bihcv_pkg::REG_PAYLOAD_LENGTH] = $urandom_range(HDR_LEN, 24);
                next_regs[bihcv_pkg::REG_CRC_INIT]       = 32'h0;
                next_regs[bihcv_pkg::REG_CRC_POLY]       = 32'h0;
            end
            SET_BAD_LENGTH: begin
                if ($urandom_range(0, 1) == 0) begin
                    next_regs[bihcv_pkg::REG_LOAD_ADDRESS]   = 32'h0;
                    next_regs[bihcv_pkg::REG_PAYLOAD_LENGTH] = $urandom_range(0, 65535);
                end else begin
                    next_regs[bihcv_pkg::REG_PAYLOAD_LENGTH] = $urandom_range(0, HDR_LEN - 1);
                end
            end
            default: ;
        endcase
    endtask

    // one image from the current settings, well-formed or with one flaw
    task automatic build_image(input bit clean);
        logic [7:0] hdr [HDR_LEN];
        logic [7:0] body [$];
        logic [15:0] crc;
        img_byte_t  ib;
        int         flaw;
        int         p;
        int         cut;
        img_q.delete();
        flaw = clean ? 0 : $urandom_range(0, 99);
        if (c_load == 16'h0000 || c_length < HDR_LEN || flaw >= 95) begin
            // noise, or a start that fails on the spot
            repeat ($urandom_range(1, 10)) begin
                ib.data  = 8'($urandom());
                ib.start = ($urandom_range(0, 9) == 0);
                img_q.push_back(ib);
            end
            if (flaw < 95) begin
                img_q[0].start = 1'b1;
            end
            return;
        end
        crc = c_init;
        for (int k = 0; k < int'(c_length); k++) begin
            body.push_back(8'($urandom()));
            crc = advance_crc(crc, body[k], c_poly);
        end
        for (int k = 0; k < 4; k++) begin
            hdr[k]     = c_magic[8 * k +: 8];
            hdr[6 + k] = c_profile[8 * k +: 8];
        end
        hdr[4]  = c_version;
        hdr[5]  = 8'(HDR_LEN);
        hdr[10] = c_load[7:0];
        hdr[11] = c_load[15:8];
        hdr[12] = c_entry[7:0];
        hdr[13] = c_entry[15:8];
        hdr[14] = c_length[7:0];
        hdr[15] = c_length[15:8];
        hdr[16] = crc[7:0];
        hdr[17] = crc[15:8];
        if (flaw >= 55 && flaw < 85) begin
            // spoil one byte of one header field, each field equally often
            case ($urandom_range(0, 7))
                0:       p = $urandom_range(0, 3);
                1:       p = 4;
                2:       p = 5;
                3:       p = $urandom_range(6, 9);
                4:       p = $urandom_range(10, 11);
                5:       p = $urandom_range(12, 13);
                6:       p = $urandom_range(14, 15);
                default: p = $urandom_range(16, 17);
            endcase
            hdr[p] = hdr[p] ^ 8'($urandom_range(1, 255));
        end
        cut = HDR_LEN + int'(c_length);
        if (flaw >= 85) begin
            cut = $urandom_range(1, cut - 1);
        end
        for (int k = 0; k < cut; k++) begin
            if (k < HDR_LEN) begin
                ib.data = hdr[k];
            end else begin
                ib.data = body[k - HDR_LEN];
            end
            ib.start = (k == 0);
            img_q.push_back(ib);
        end
    endtask

    task automatic send_image();
        foreach (img_q[i]) begin
            send_word(img_q[i].data, img_q[i].start, 1'b0, bihcv_pkg::ST_OK, 16'h0000);
        end
    endtask

    function automatic dir_row_t byte_row(logic [7:0] d, logic st);
        dir_row_t r;
        r.kind   = ROW_BYTE;
        r.addr   = bihcv_pkg::REG_IMAGE_MAGIC;
        r.value  = {24'h0, d};
        r.start  = st;
        r.fixed  = 1'b0;
        r.status = bihcv_pkg::ST_OK;
        r.crc    = 16'h0000;
        return r;
    endfunction

    function automatic dir_row_t fixed_row(logic [7:0] d, logic st, logic [3:0] status,
                                           logic [15:0] crc);
        dir_row_t r;
        r        = byte_row(d, st);
        r.fixed  = 1'b1;
        r.status = status;
        r.crc    = crc;
        return r;
    endfunction

    function automatic dir_row_t reg_row(logic [2:0] addr, logic [31:0] val);
        dir_row_t r;
        r       = byte_row(8'h00, 1'b0);
        r.kind  = ROW_CFG;
        r.addr  = addr;
        r.value = val;
        return r;
    endfunction

    initial begin : stimulus
        dir_row_t rows [$];
        setting_t mode;
        int       phase;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr  = bihcv_pkg::REG_IMAGE_MAGIC;
        cfg_wdata = 32'h0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset registers: load address zero fails any start
        rows.push_back(fixed_row(8'h00, 1'b1, bihcv_pkg::ST_LENGTH,
                                 bihcv_pkg::CRC_INIT_RESET));
        rows.push_back(byte_row(8'hA5, 1'b0));
        rows.push_back(reg_row(bihcv_pkg::REG_LOAD_ADDRESS, 32'h0000_FFFF));
        rows.push_back(reg_row(bihcv_pkg::REG_PAYLOAD_LENGTH, 32'h0000_FFFF));
        rows.push_back(reg_row(bihcv_pkg::REG_IMAGE_MAGIC, 32'hFFFF_FFFF));
        rows.push_back(reg_row(bihcv_pkg::REG_FORMAT_VERSION, 32'h0000_0000));
        // good magic and version, wrong header size
        rows.push_back(byte_row(8'hFF, 1'b1));
        rows.push_back(byte_row(8'hFF, 1'b0));
        rows.push_back(byte_row(8'hFF, 1'b0));
        rows.push_back(byte_row(8'hFF, 1'b0));
        rows.push_back(byte_row(8'h00, 1'b0));
        rows.push_back(fixed_row(8'h11, 1'b0, bihcv_pkg::ST_HSIZE,
                                 bihcv_pkg::CRC_INIT_RESET));
        rows.push_back(byte_row(8'h00, 1'b0));
        // restart halfway through the magic, then a bad top byte
        rows.push_back(byte_row(8'hFF, 1'b1));
        rows.push_back(byte_row(8'hFF, 1'b0));
        rows.push_back(byte_row(8'hFF, 1'b1));
        rows.push_back(byte_row(8'hFF, 1'b0));
        rows.push_back(byte_row(8'hFF, 1'b0));
        rows.push_back(fixed_row(8'h7F, 1'b0, bihcv_pkg::ST_MAGIC,
                                 bihcv_pkg::CRC_INIT_RESET));
        rows.push_back(byte_row(8'hFF, 1'b1));
        rows.push_back(byte_row(8'hFF, 1'b0));
        rows.push_back(byte_row(8'hFF, 1'b0));
        rows.push_back(byte_row(8'hFF, 1'b0));
        rows.push_back(fixed_row(8'h80, 1'b0, bihcv_pkg::ST_VERSION,
                                 bihcv_pkg::CRC_INIT_RESET));
        rows.push_back(reg_row(bihcv_pkg::REG_LOAD_ADDRESS, 32'h0000_0000));
        rows.push_back(fixed_row(8'hFF, 1'b1, bihcv_pkg::ST_LENGTH,
                                 bihcv_pkg::CRC_INIT_RESET));
        // length one short of the header
        rows.push_back(reg_row(bihcv_pkg::REG_LOAD_ADDRESS, 32'h0000_0001));
        rows.push_back(reg_row(bihcv_pkg::REG_PAYLOAD_LENGTH, 32'(HDR_LEN - 1)));
        rows.push_back(fixed_row(8'h00, 1'b1, bihcv_pkg::ST_LENGTH,
                                 bihcv_pkg::CRC_INIT_RESET));
        rows.push_back(reg_row(bihcv_pkg::REG_CRC_INIT, 32'h0000_0000));
        rows.push_back(fixed_row(8'hFF, 1'b1, bihcv_pkg::ST_LENGTH, 16'h0000));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                settle_block();
                write_reg(rows[i].addr, rows[i].value);
            end else begin
                send_word(rows[i].value[7:0], rows[i].start, rows[i].fixed,
                          rows[i].status, rows[i].crc);
            end
        end

        phase = 0;
        while (phase < 6 || accepted_items < ITEM_GOAL) begin
            if (phase == 4) begin
                // every start fails, so results pile up behind a stalled sink
                pick_settings(SET_RANDOM);
                next_regs[bihcv_pkg::REG_LOAD_ADDRESS] = 32'h0;
                load_regs();
                no_gaps  = 1'b1;
                hold_len = HOLD_CYCLES;
                repeat (60) begin
                    send_word(8'($urandom()), 1'b1, 1'b0, bihcv_pkg::ST_OK, 16'h0000);
                end
                settle_block();
            end
            case (phase)
                0: mode = SET_ONES;
                1: mode = SET_ZEROS;
                2: mode = SET_BAD_LENGTH;
                default: begin
                    case ($urandom_range(0, 9))
                        0:       mode = SET_ONES;
                        1:       mode = SET_ZEROS;
                        2:       mode = SET_BAD_LENGTH;
                        default: mode = SET_RANDOM;
                    endcase
                end
            endcase
            no_gaps = (phase % 6 == 5);
            pick_settings(mode);
            load_regs();
            // carry on with a possibly unfinished image under the new registers
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 20)) begin
                    send_word(8'($urandom()), 1'b0, 1'b0, bihcv_pkg::ST_OK, 16'h0000);
                end
            end
            repeat ($urandom_range(2, 5)) begin
                build_image(1'b0);
                send_image();
            end
            phase++;
        end

        // one clean image with a long payload
        no_gaps = ($urandom_range(0, 1) == 0);
        pick_settings(SET_RANDOM);
        next_regs[bihcv_pkg::REG_PAYLOAD_LENGTH] = $urandom_range(64, 96);
        load_regs();
        build_image(1'b1);
        send_image();
        settle_block();

        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
